// ===== hdl/gclp_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gclp_pkg: shared types and constants for the grid coordinate line parser
// Scan phases, register indexes, configuration and result records.
// -----------------------------------------------------------------------------
package gclp_pkg;

   localparam int VAL_W     = 24;
   localparam int CHAR_W    = 8;
   localparam int MASK_W    = 4;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 4;

   // Digit counts that take part in matching
   localparam int MATCH_MIN  = 4;
   localparam int MATCH_MAX  = 7;
   localparam int NORTH_WIDE = 7;
   localparam int EAST_WIDE  = 6;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_FIRST,
      PH_GAP,
      PH_SECOND,
      PH_TRAIL
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE = 1'b0,
      CSR_MASK = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              mode;
      logic [MASK_W-1:0] mask;
   } cfg_type;

   typedef struct packed {
      logic             accepted;
      logic             well_formed;
      logic [VAL_W-1:0] north_value;
      logic [VAL_W-1:0] east_value;
   } result_type;

endpackage

// ===== hdl/gclp_scan.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gclp_scan: line scanner
// Holds the per-line scan state, steps it by one byte, and forms the result
// from the current state when the end marker arrives.
// -----------------------------------------------------------------------------
module gclp_scan
   import gclp_pkg::*;
#(
   parameter int MAX_DIGITS = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step_valid,
   input  logic [CHAR_W-1:0] step_char,
   input  logic              step_end,
   input  cfg_type           cfg,
   output result_type        result
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 2);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_DIGITS);
   localparam logic [CNT_W-1:0] CNT_OVER  = CNT_W'(MAX_DIGITS + 1);

   phase_type        phase_ff, phase_in;
   logic             err_ff, err_in;
   logic [VAL_W-1:0] north_ff, north_in, east_ff, east_in;
   logic [CNT_W-1:0] ncnt_ff, ncnt_in, ecnt_ff, ecnt_in;

   logic [CHAR_W-1:0] diff;
   logic [3:0]        digit_val;
   logic              is_digit, is_space, nonzero;
   logic              live, north_full, east_full, north_take, east_take;
   logic              well_formed, n_usable, wide_pair, accept_bit;

   assign diff      = step_char - CHAR_ZERO;
   assign digit_val = diff[3:0];
   assign is_digit  = (step_char >= CHAR_ZERO) && (step_char <= CHAR_NINE);
   assign is_space  = (step_char == CHAR_SPACE) ||
                      ((step_char >= CHAR_TAB) && (step_char <= CHAR_CR));
   assign nonzero   = (digit_val != 4'd0);
   assign live      = step_valid && !step_end && !err_ff;
   assign north_full = (ncnt_ff >= CNT_LIMIT);
   assign east_full  = (ecnt_ff >= CNT_LIMIT);

   assign north_take = live && is_digit &&
                       (((phase_ff == PH_LEAD) && nonzero) || (phase_ff == PH_FIRST));
   assign east_take  = live && is_digit &&
                       (((phase_ff == PH_GAP) && nonzero) || (phase_ff == PH_SECOND));

   // Next scan phase and sticky error
   always_comb begin
      phase_in = phase_ff;
      err_in   = err_ff;
      if (step_valid && step_end) begin
         phase_in = PH_LEAD;
         err_in   = 1'b0;
      end else if (live) begin
         unique case (phase_ff)
            PH_LEAD: begin
               if (is_digit && nonzero) phase_in = PH_FIRST;
               else if (!is_space) err_in = 1'b1;
            end
            PH_GAP: begin
               if (is_digit && nonzero) phase_in = PH_SECOND;
               else if (!is_space) err_in = 1'b1;
            end
            PH_FIRST: begin
               if (is_digit) begin
                  if (north_full) err_in = 1'b1;
               end else if (is_space) phase_in = PH_GAP;
               else err_in = 1'b1;
            end
            PH_SECOND: begin
               if (is_digit) begin
                  if (east_full) err_in = 1'b1;
               end else if (is_space) phase_in = PH_TRAIL;
               else err_in = 1'b1;
            end
            default: begin
               if (!is_space) err_in = 1'b1;
            end
         endcase
      end
   end

   // Accumulators and digit counts: value * 10 + digit, count saturates past limit
   always_comb begin
      north_in = north_ff;
      east_in  = east_ff;
      ncnt_in  = ncnt_ff;
      ecnt_in  = ecnt_ff;
      if (step_valid && step_end) begin
         north_in = '0;
         east_in  = '0;
         ncnt_in  = '0;
         ecnt_in  = '0;
      end else begin
         if (north_take) begin
            if (north_full) begin
               ncnt_in = CNT_OVER;
            end else begin
               north_in = {north_ff[VAL_W-4:0], 3'b000} + {north_ff[VAL_W-2:0], 1'b0}
                          + VAL_W'(digit_val);
               ncnt_in  = ncnt_ff + CNT_W'(1);
            end
         end
         if (east_take) begin
            if (east_full) begin
               ecnt_in = CNT_OVER;
            end else begin
               east_in = {east_ff[VAL_W-4:0], 3'b000} + {east_ff[VAL_W-2:0], 1'b0}
                         + VAL_W'(digit_val);
               ecnt_in = ecnt_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LEAD;
         err_ff   <= 1'b0;
         north_ff <= '0;
         east_ff  <= '0;
         ncnt_ff  <= '0;
         ecnt_ff  <= '0;
      end else if (step_valid) begin
         phase_ff <= phase_in;
         err_ff   <= err_in;
         north_ff <= north_in;
         east_ff  <= east_in;
         ncnt_ff  <= ncnt_in;
         ecnt_ff  <= ecnt_in;
      end
   end

   // Verdict from the state before the end marker; counts 4..7 index the mask by low bits
   assign well_formed = !err_ff && ((phase_ff == PH_SECOND) || (phase_ff == PH_TRAIL));
   assign n_usable    = (ncnt_ff >= CNT_W'(MATCH_MIN)) && (ncnt_ff <= CNT_W'(MATCH_MAX));
   assign wide_pair   = (ncnt_ff == CNT_W'(NORTH_WIDE)) && (ecnt_ff == CNT_W'(EAST_WIDE));
   assign accept_bit  = cfg.mask[ncnt_ff[1:0]];

   always_comb begin
      result = '0;
      if (well_formed) begin
         result.well_formed = 1'b1;
         result.north_value = north_ff;
         result.east_value  = east_ff;
         if (wide_pair) result.accepted = !cfg.mode;
         else result.accepted = (ncnt_ff == ecnt_ff) && cfg.mode && n_usable && accept_bit;
      end
   end

endmodule

// ===== hdl/grid_coordinate_line_parser_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// grid_coordinate_line_parser_core: coordinate text line parser
// Checks a byte stream line against the two-number coordinate syntax and
// reports the two values and whether the digit counts fit the asked grid.
// -----------------------------------------------------------------------------
// Throughput: one byte per cycle through an input register, unless an end marker waits.
// Path: an end marker is taken into the input register, then the scan step
// forms the line's result into the result register that drives rsp_.
// Stalls: only an end marker waits, and only while the previous result is held.
// Reset: clears the scan state and both stages; mode reads 1, mask reads 15.
// Only end markers produce a transfer on the result channel.
module grid_coordinate_line_parser_core
   import gclp_pkg::*;
#(
   parameter int MAX_DIGITS = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CHAR_W-1:0]    req_char_code,
   input  logic                 req_end_of_text,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_accepted,
   output logic                 rsp_well_formed,
   output logic [VAL_W-1:0]     rsp_north_value,
   output logic [VAL_W-1:0]     rsp_east_value,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data
);

   cfg_type           cfg_ff;
   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_end_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;
   result_type        result;
   logic              advance, fire;

   // plain bytes never touch the result register; only an end marker needs it free
   assign advance   = !in_end_ff || !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= 1'b1;
         cfg_ff.mask <= '1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODE: cfg_ff.mode <= csr_data[0];
            CSR_MASK: cfg_ff.mask <= csr_data[MASK_W-1:0];
            default:  cfg_ff <= cfg_ff;
         endcase
      end
   end

   // Input stage: hold an end marker while the previous result is stalled
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_code;
         in_end_ff  <= req_end_of_text;
      end
   end

   gclp_scan #(
      .MAX_DIGITS(MAX_DIGITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step_valid (fire),
      .step_char  (in_char_ff),
      .step_end   (in_end_ff),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // Result stage: load on an end marker, drop after the transfer
   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire && in_end_ff) out_valid_in = 1'b1;
      else if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (fire && in_end_ff) out_ff <= result;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_accepted    = out_ff.accepted;
   assign rsp_well_formed = out_ff.well_formed;
   assign rsp_north_value = out_ff.north_value;
   assign rsp_east_value  = out_ff.east_value;

`ifndef SYNTHESIS
   a_stall_needs_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input stage");

   a_accept_needs_syntax: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_well_formed)
      else $error("accepted line that is not well formed");

   a_bad_line_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_well_formed |->
         rsp_north_value == '0 && rsp_east_value == '0 && !rsp_accepted)
      else $error("values not cleared on a malformed line");

   a_good_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_north_value != '0 && rsp_east_value != '0)
      else $error("accepted line with a zero value");

   a_result_from_end: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff && !(fire && in_end_ff) |=> !out_valid_ff)
      else $error("result appeared without an end marker");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb: self-checking testbench for grid_coordinate_line_parser_core
// Streams coordinate text lines byte by byte, predicts each end-of-line result
// from a local copy of the scan state and registers, and compares every result
// transfer field by field. Covers directed corner lines, randomized lines under
// a sweep of register settings, sender gaps, receiver stalls and a long
// receiver hold-off.
// -----------------------------------------------------------------------------
module tb;
   import gclp_pkg::*;

   localparam int MAX_DIGITS   = 7;
   localparam int RESET_CYCLES = 6;
   localparam int DRAIN_CYCLES = 6;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_BYTES  = 100;
   localparam int SWEEP_PHASES = 10;
   localparam int TIMEOUT_NS   = 2_000_000;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_style_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [CHAR_W-1:0]    req_char_code;
   logic                 req_end_of_text;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_accepted;
   logic                 rsp_well_formed;
   logic [VAL_W-1:0]     rsp_north_value;
   logic [VAL_W-1:0]     rsp_east_value;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_data;

   // predicted line state and register copy
   cfg_type          grid_cfg;
   phase_type        line_phase;
   logic [VAL_W-1:0] num_value [2];
   int               num_digits [2];
   bit               line_broken;
   result_type       pending_coords [$];

   // traffic shaping
   stall_style_type  stall_style  = STALL_NONE;
   bit               hold_request = 1'b0;
   bit               sender_gaps  = 1'b0;
   int               burst_left   = 0;
   int               noise_pct    = 0;

   int fail_count     = 0;
   int bytes_sent     = 0;
   int lines_sent     = 0;
   int lines_accepted = 0;
   int lines_bad      = 0;
   int settings_used  = 0;

   grid_coordinate_line_parser_core #(
      .MAX_DIGITS(MAX_DIGITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .req_end_of_text(req_end_of_text),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_accepted   (rsp_accepted),
      .rsp_well_formed(rsp_well_formed),
      .rsp_north_value(rsp_north_value),
      .rsp_east_value (rsp_east_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // ---------------------------------------------------------------- predictor
   function automatic bit is_blank(logic [CHAR_W-1:0] c);
      return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
   endfunction

   function automatic int grid_digits(int n);
      if (n < MATCH_MIN) return 0;
      if (n > MATCH_MAX) return MATCH_MAX + 1;
      return n;
   endfunction

   task automatic clear_line_model();
      line_phase    = PH_LEAD;
      num_value[0]  = '0;
      num_value[1]  = '0;
      num_digits[0] = 0;
      num_digits[1] = 0;
      line_broken   = 1'b0;
   endtask

   task automatic add_digit(input int which, input logic [CHAR_W-1:0] c);
      if (num_digits[which] < MAX_DIGITS) begin
         num_value[which]  = num_value[which] * 10 + VAL_W'(c - CHAR_ZERO);
         num_digits[which] = num_digits[which] + 1;
      end else begin
         // saturate the count and poison the line
         num_digits[which] = MAX_DIGITS + 1;
         line_broken       = 1'b1;
      end
   endtask

   task automatic track_coordinate_byte(input logic [CHAR_W-1:0] ch, input logic eot);
      result_type r;
      bit         digit;
      bit         blank;
      int         dn;
      int         de;
      digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      blank = is_blank(ch);
      if (!eot) begin
         if (!line_broken) begin
            case (line_phase)
               PH_LEAD, PH_GAP: begin
                  if (!blank) begin
                     if (digit && ch != CHAR_ZERO) begin
                        if (line_phase == PH_LEAD) begin
                           add_digit(0, ch);
                           line_phase = PH_FIRST;
                        end else begin
                           add_digit(1, ch);
                           line_phase = PH_SECOND;
                        end
                     end else begin
                        line_broken = 1'b1;
                     end
                  end
               end
               PH_FIRST: begin
                  if (digit) add_digit(0, ch);
                  else if (blank) line_phase = PH_GAP;
                  else line_broken = 1'b1;
               end
               PH_SECOND: begin
                  if (digit) add_digit(1, ch);
                  else if (blank) line_phase = PH_TRAIL;
                  else line_broken = 1'b1;
               end
               default: begin
                  if (!blank) line_broken = 1'b1;
               end
            endcase
         end
      end else begin
         r = '0;
         r.well_formed = !line_broken && (line_phase == PH_SECOND || line_phase == PH_TRAIL);
         if (r.well_formed) begin
            dn = grid_digits(num_digits[0]);
            de = grid_digits(num_digits[1]);
            r.north_value = num_value[0];
            r.east_value  = num_value[1];
            if (dn == NORTH_WIDE && de == EAST_WIDE) begin
               r.accepted = !grid_cfg.mode;
            end else begin
               r.accepted = (dn == de) && grid_cfg.mode && dn >= MATCH_MIN &&
                            dn <= MATCH_MAX && grid_cfg.mask[dn - MATCH_MIN];
            end
         end
         pending_coords.insert(pending_coords.size(), r);
         lines_sent++;
         if (r.accepted) lines_accepted++;
         if (!r.well_formed) lines_bad++;
         clear_line_model();
      end
   endtask

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_coords.size() == 0) begin
            $error("result transfer with no line pending");
            fail_count++;
         end else begin
            want = pending_coords.pop_front();
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0d, got %0d", want.accepted, rsp_accepted);
               fail_count++;
            end
            if (rsp_well_formed !== want.well_formed) begin
               $error("well_formed: expected %0d, got %0d", want.well_formed,
                      rsp_well_formed);
               fail_count++;
            end
            if (rsp_north_value !== want.north_value) begin
               $error("north_value: expected %0d, got %0d", want.north_value,
                      rsp_north_value);
               fail_count++;
            end
            if (rsp_east_value !== want.east_value) begin
               $error("east_value: expected %0d, got %0d", want.east_value,
                      rsp_east_value);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   initial begin : receiver
      int cyc;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_request) begin
            // hold off long enough for the parser to back up into its input
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            for (int i = 1; i < HOLD_CYCLES; i++) @(posedge clock);
         end else begin
            case (stall_style)
               STALL_NONE:  rsp_stall <= 1'b0;
               STALL_LIGHT: rsp_stall <= ($urandom_range(0, 99) < 25);
               STALL_HEAVY: rsp_stall <= ($urandom_range(0, 99) < 75);
               default:     rsp_stall <= ((cyc % 11) < 4);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- sender
   task automatic send_byte(input logic [CHAR_W-1:0] ch, input logic eot);
      int gap;
      if (sender_gaps) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end else begin
            burst_left--;
         end
      end
      req_valid       <= 1'b1;
      req_char_code   <= ch;
      req_end_of_text <= eot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_coordinate_byte(ch, eot);
      bytes_sent++;
   endtask

   // the character code is don't-care on an end marker, so randomize it
   task automatic end_line();
      send_byte(CHAR_W'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_line(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
      end_line();
   endtask

   task automatic send_line_byte(input logic [CHAR_W-1:0] ch);
      if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) begin
         ch = CHAR_W'($urandom_range(0, 255));
      end
      send_byte(ch, 1'b0);
   endtask

   task automatic send_blanks(input int n);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 5);
         send_line_byte((k == 5) ? CHAR_SPACE : CHAR_W'(CHAR_TAB + k));
      end
   endtask

   task automatic send_number(input int n, input bit zero_first);
      int d;
      for (int i = 0; i < n; i++) begin
         if (i == 0) d = zero_first ? 0 : $urandom_range(1, 9);
         else d = $urandom_range(0, 9);
         send_line_byte(CHAR_W'(CHAR_ZERO + d));
      end
   endtask

   task automatic send_random_line();
      int kind;
      int flaw;
      int nd;
      int ed;
      kind = $urandom_range(0, 99);
      flaw = $urandom_range(0, 99);
      if (kind < 25) begin
         nd = NORTH_WIDE;
         ed = EAST_WIDE;
      end else if (kind < 60) begin
         nd = $urandom_range(MATCH_MIN, MATCH_MAX);
         ed = nd;
      end else begin
         nd = $urandom_range(1, MAX_DIGITS + 2);
         ed = $urandom_range(1, MAX_DIGITS + 2);
      end
      noise_pct = (flaw >= 80 && flaw < 88) ? 8 : 0;
      send_blanks($urandom_range(0, 2));
      send_number(nd, flaw >= 88 && flaw < 90);
      if (flaw >= 92 && flaw < 96) begin
         // end the line before the second number starts
         send_blanks($urandom_range(0, 1));
      end else begin
         send_blanks($urandom_range(1, 2));
         send_number(ed, flaw >= 90 && flaw < 92);
         send_blanks($urandom_range(0, 2));
         if (flaw >= 96) begin
            send_blanks(1);
            send_number($urandom_range(1, 3), 1'b0);
         end
      end
      noise_pct = 0;
      end_line();
   endtask

   // ---------------------------------------------------------------- registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_coords.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_MODE) grid_cfg.mode = data[0];
      else grid_cfg.mask = data[MASK_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // the mode register only looks at bit 0; scramble the rest
   task automatic set_grid(input logic mode, input logic [MASK_W-1:0] mask);
      wait_idle();
      write_csr(CSR_MODE, {3'($urandom_range(0, 7)), mode});
      write_csr(CSR_MASK, mask);
      settings_used++;
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      stall_style = STALL_LIGHT;
      sender_gaps = 1'b1;
      send_line("\t1234567 123456\015");
      send_line("9999999 9999999");
      send_line("\n\013\0141234 5678 ");
      send_line("1 2");
      send_line("0 5");
      send_line("12345678 1");
      send_line("12a 3");
      send_line("1 2 3");
      send_line("12 ");
      send_line("");
      send_line("1 ");
      send_byte(8'h00, 1'b0);
      send_line("2");
      send_line("1 2 ");
      send_byte(8'hFF, 1'b0);
      end_line();
      set_grid(1'b0, 4'b1111);
      send_line("1234567 123456");
      send_line("1234 5678");
   endtask

   task automatic test_config_sweep();
      int start;
      for (int p = 0; p < SWEEP_PHASES; p++) begin
         case (p)
            0:       set_grid(1'b1, 4'b0000);
            1:       set_grid(1'b0, 4'b1111);
            2:       set_grid(1'b0, 4'b0000);
            3:       set_grid(1'b1, 4'b1111);
            4:       set_grid(1'b1, 4'b0101);
            5:       set_grid(1'b1, 4'b1010);
            default: set_grid(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
         endcase
         stall_style = stall_style_type'(p % 4);
         sender_gaps = (p % 3) != 2;
         start = bytes_sent;
         while (bytes_sent - start < PHASE_BYTES) send_random_line();
      end
   endtask

   task automatic test_backpressure();
      set_grid(1'b1, 4'b1111);
      stall_style  = STALL_NONE;
      sender_gaps  = 1'b0;
      hold_request = 1'b1;
      for (int i = 0; i < 30; i++) send_random_line();
   endtask

   task automatic test_no_idle();
      int start;
      set_grid(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      stall_style = STALL_NONE;
      sender_gaps = 1'b0;
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) send_random_line();
   endtask

   // ---------------------------------------------------------------- main
   initial begin
      int guard;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_char_code   = '0;
      req_end_of_text = 1'b0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = CSR_MODE;
      csr_data        = '0;
      grid_cfg.mode   = 1'b1;
      grid_cfg.mask   = 4'b1111;
      clear_line_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_config_sweep();
      test_backpressure();
      test_no_idle();

      req_valid   <= 1'b0;
      stall_style  = STALL_LIGHT;
      guard        = 0;
      while (pending_coords.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_coords.size() != 0) begin
         $error("%0d line results never arrived", pending_coords.size());
         fail_count++;
      end
      $display("tb: %0d bytes in %0d lines, %0d accepted, %0d malformed",
               bytes_sent, lines_sent, lines_accepted, lines_bad);
      $display("tb: %0d register settings, stalls, gaps and one long hold-off",
               settings_used);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb: failure");
      $finish;
   end

endmodule
